// File: hw/rtl/uer_pkg.sv
package uer_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] REG_TRIG_PULSE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'b1;

	// register reset values
	localparam logic [15:0] TRIG_PULSE_RST = 16'd20;
	localparam logic [23:0] TIMEOUT_RST = 24'd50000;

	localparam int RING_SLOTS_DEF = 128;
	localparam int QUEUE_DEPTH = 2;

	localparam int WIDTH_W = 32;
	localparam int ENTRY_W = WIDTH_W + 1;
	localparam int HELD_W = 7;

	// ring entry: top bit flags a timeout marker
	localparam logic [ENTRY_W-1:0] ENTRY_TIMEOUT = {1'b1, {WIDTH_W{1'b0}}};

	typedef struct packed {
		logic echo_level;
		logic trigger_request;
		logic pop_request;
	} in_item_t;

	typedef struct packed {
		logic               trigger_out;
		logic               pop_valid;
		logic               pop_timeout;
		logic [WIDTH_W-1:0] pop_width;
		logic               result_stored;
		logic [HELD_W-1:0]  entries_held;
	} out_item_t;

	// classified tick handed from front to back
	typedef struct packed {
		logic               trig_out;
		logic               pop;
		logic               push;
		logic [ENTRY_W-1:0] entry;
	} op_t;

endpackage

// File: hw/rtl/uer_stream_if.sv
interface uer_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/uer_front.sv
module uer_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            acc,
	input  uer_pkg::in_item_t               item,
	input  logic                            cfg_we,
	input  logic [uer_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [uer_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output uer_pkg::op_t                    op
);

	logic [15:0] pulse_cfg_q;
	logic [23:0] timeout_cfg_q;

	logic        prev_q, armed_q, to_armed_q;
	logic [31:0] width_q;
	logic [15:0] pulse_q;
	logic [23:0] to_rem_q;

	logic        armed_d, to_armed_d;
	logic [31:0] width_d;
	logic [15:0] pulse_d;
	logic [23:0] to_rem_d;
	logic        fall, just_armed, trig, to_push;

	always_comb begin
		armed_d = armed_q;
		width_d = width_q;
		to_armed_d = to_armed_q;
		to_rem_d = to_rem_q;
		fall = 1'b0;
		// echo edges
		if (item.echo_level && !prev_q) begin
			armed_d = 1'b1;
			width_d = 32'd1;
		end else if (item.echo_level) begin
			if (armed_q && width_q != '1) width_d = width_q + 32'd1;
		end else if (prev_q && armed_q) begin
			fall = 1'b1;
			armed_d = 1'b0;
			width_d = '0;
			to_armed_d = 1'b0;
			to_rem_d = '0;
		end
		// trigger pulse
		pulse_d = pulse_q;
		just_armed = 1'b0;
		trig = 1'b0;
		if (pulse_q == '0 && item.trigger_request)
			pulse_d = (pulse_cfg_q == '0) ? 16'd1 : pulse_cfg_q;
		if (pulse_d != '0) begin
			trig = 1'b1;
			pulse_d = pulse_d - 16'd1;
			if (pulse_d == '0) begin
				to_armed_d = 1'b1;
				to_rem_d = (timeout_cfg_q == '0) ? 24'd1 : timeout_cfg_q;
				just_armed = 1'b1;
			end
		end
		// timeout countdown
		to_push = 1'b0;
		if (to_armed_d && !just_armed) begin
			if (to_rem_d != '0) to_rem_d = to_rem_d - 24'd1;
			if (to_rem_d == '0) begin
				to_armed_d = 1'b0;
				to_push = !fall;
			end
		end
		op.trig_out = trig;
		op.pop = item.pop_request;
		op.push = fall || to_push;
		op.entry = fall ? {1'b0, width_q} : uer_pkg::ENTRY_TIMEOUT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_cfg_q <= uer_pkg::TRIG_PULSE_RST;
			timeout_cfg_q <= uer_pkg::TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				uer_pkg::REG_TRIG_PULSE: pulse_cfg_q <= cfg_wdata[15:0];
				uer_pkg::REG_TIMEOUT:    timeout_cfg_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 1'b0;
			armed_q <= 1'b0;
			width_q <= '0;
			pulse_q <= '0;
			to_armed_q <= 1'b0;
			to_rem_q <= '0;
		end else if (acc) begin
			prev_q <= item.echo_level;
			armed_q <= armed_d;
			width_q <= width_d;
			pulse_q <= pulse_d;
			to_armed_q <= to_armed_d;
			to_rem_q <= to_rem_d;
		end
	end

endmodule

// File: hw/rtl/uer_queue.sv
module uer_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  uer_pkg::op_t wr_op,
	output logic         not_full,
	output logic         rd_valid,
	input  logic         rd_en,
	output uer_pkg::op_t rd_op
);

	localparam int PTR_W = (uer_pkg::QUEUE_DEPTH > 1) ? $clog2(uer_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(uer_pkg::QUEUE_DEPTH + 1);

	uer_pkg::op_t     slot_q [uer_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	function automatic logic [PTR_W-1:0] step(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(uer_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign not_full = (count_q != CNT_W'(uer_pkg::QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_op = slot_q[head_q];
	assign push = wr_en && not_full;
	assign pop = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (push) slot_q[tail_q] <= wr_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
		end else begin
			if (push) tail_q <= step(tail_q);
			if (pop) head_q <= step(head_q);
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: hw/rtl/uer_back.sv
module uer_back #(
	parameter int RING_SLOTS = uer_pkg::RING_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              op_valid,
	input  uer_pkg::op_t      op,
	output logic              op_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output uer_pkg::out_item_t out_data
);

	localparam int PTR_W = $clog2(RING_SLOTS);

	logic [uer_pkg::ENTRY_W-1:0] ring [RING_SLOTS];

	logic [PTR_W-1:0] rp_q, wp_q, rp_n, wp_n;
	logic             pop_ok, push_ok, adv;
	logic [PTR_W:0]   held;

	logic                        s2_valid_q;
	logic                        trig_s2, popv_s2, stored_s2;
	logic [uer_pkg::HELD_W-1:0]  held_s2;
	logic [uer_pkg::ENTRY_W-1:0] rd_s2;

	function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(RING_SLOTS - 1)) ? '0 : p + 1'b1;
	endfunction

	assign op_ready = !s2_valid_q || out_ready;
	assign adv = op_valid && op_ready;

	// pop sees the ring as it stood before this tick's push
	always_comb begin
		pop_ok = op.pop && (rp_q != wp_q);
		rp_n = pop_ok ? nxt(rp_q) : rp_q;
		push_ok = op.push && (nxt(wp_q) != rp_n);
		wp_n = push_ok ? nxt(wp_q) : wp_q;
		if (wp_n >= rp_n)
			held = {1'b0, wp_n} - {1'b0, rp_n};
		else
			held = {1'b0, wp_n} + (PTR_W+1)'(RING_SLOTS) - {1'b0, rp_n};
	end

	always_ff @(posedge clk) begin
		if (adv && push_ok) ring[wp_q] <= op.entry;
		if (adv && pop_ok) rd_s2 <= ring[rp_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q <= '0;
			wp_q <= '0;
			s2_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				rp_q <= rp_n;
				wp_q <= wp_n;
			end
			if (op_ready) s2_valid_q <= op_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			trig_s2 <= op.trig_out;
			popv_s2 <= pop_ok;
			stored_s2 <= push_ok;
			held_s2 <= uer_pkg::HELD_W'(held);
		end
	end

	assign out_valid = s2_valid_q;

	always_comb begin
		out_data.trigger_out = trig_s2;
		out_data.pop_valid = popv_s2;
		out_data.pop_timeout = popv_s2 && rd_s2[uer_pkg::WIDTH_W];
		out_data.pop_width = (popv_s2 && !rd_s2[uer_pkg::WIDTH_W]) ?
			rd_s2[uer_pkg::WIDTH_W-1:0] : '0;
		out_data.result_stored = stored_s2;
		out_data.entries_held = held_s2;
	end

endmodule

// File: hw/rtl/ultrasonic_echo_ranger.sv
// path: a taken tick goes into the queue and from there into the output register,
// from which its result transaction is taken; a result-side stall holds it in the queue
// throughput: one tick per cycle while the queue has room; the front keeps its counters
// in registers and the ring memory has one write and one registered read port per cycle
// reset: arst_n clears all control state and restores the register defaults;
// the result ring itself is not cleared and needs no clearing pass
module ultrasonic_echo_ranger #(
	parameter int RING_SLOTS = uer_pkg::RING_SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	uer_stream_if.sink                      samples,
	uer_stream_if.source                    results,
	input  logic                            cfg_we,
	input  logic [uer_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [uer_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	// front to queue
	uer_pkg::op_t front_op;
	logic         q_not_full;
	logic         sample_acc;

	// queue to back
	uer_pkg::op_t back_op;
	logic         back_valid, back_ready;

	// a sample transaction is taken whenever the queue has room
	assign samples.ready = q_not_full;
	assign sample_acc = samples.valid && q_not_full;

	// front: echo edge detection, trigger pulse and timeout timers
	uer_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (sample_acc),
		.item      (samples.data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.op        (front_op)
	);

	// short queue so the front keeps sampling while the result side stalls, until it fills
	uer_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (sample_acc),
		.wr_op    (front_op),
		.not_full (q_not_full),
		.rd_valid (back_valid),
		.rd_en    (back_ready),
		.rd_op    (back_op)
	);

	// back: ring pointers, ring memory and the output register
	uer_back #(
		.RING_SLOTS (RING_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (back_valid),
		.op        (back_op),
		.op_ready  (back_ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.out_data  (results.data)
	);

endmodule

// File: hw/rtl/uer_checker.sv
module uer_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input uer_pkg::out_item_t out_data
);

	// a stalled result transaction keeps its valid
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	// a stalled result transaction keeps its payload
	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result payload changed while stalled");

	// a timeout marker only comes from a real pop and carries no width
	a_timeout_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.pop_timeout |->
			out_data.pop_valid && out_data.pop_width == '0)
		else $error("malformed timeout marker");

	// after a push the ring cannot be empty
	a_stored_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.result_stored |-> out_data.entries_held != '0)
		else $error("entry stored but ring reported empty");

endmodule

bind ultrasonic_echo_ranger uer_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_data  (results.data)
);
